### rtl/rde_pkg.sv
package rde_pkg;

  localparam int SYM_W       = 8;
  localparam int NUM_SYMBOLS = 16;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEPS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic digit_store;
    logic rd_en;
    logic ptr_dec;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic alphabet_ok;
    logic neg;
    logic div_last;
    logic mag_zero;
    logic buf_full;
    logic ptr_zero;
    logic slot_free;
  } status_t;

  function automatic logic sym_forbidden(input logic [SYM_W-1:0] c);
    return (c == CHAR_NUL) || (c == CHAR_PLUS) || (c == CHAR_MINUS) ||
           (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

### rtl/radix_digit_emitter.sv
// radix_digit_emitter: converts one signed two's complement value per item into text in a
// programmable radix (2 to MAX_RADIX) using a programmable 16-symbol alphabet. characters
// come out most significant digit first, after a '-' for negative values, and the final
// character of each number has last set. the most negative value converts as its unsigned
// magnitude. if the alphabet is unusable (radix below 2 or above MAX_RADIX, a repeated
// symbol, or a symbol that is '+', '-', space, a byte 9..13 or zero among the first radix
// symbols) the value is consumed and nothing is emitted. timing: one value is in flight at a
// time. after the accept and the alphabet check, each digit takes a pass of the shared
// restoring divider (4 quotient bits a cycle) and a digit store write. a sign state that is
// visited whether or not a '-' goes out follows, then each character takes a digit store
// read plus an output register load, and waits while the output register is still full. the
// output register lets the next value be accepted while the last character still waits
// for its transfer. configuration registers may only be written while the block is idle.
module radix_digit_emitter #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes, always taken
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]     cfg_data,
  // input values
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic signed [VALUE_BITS-1:0]  value,
  // output characters
  output logic                          char_valid,
  input  logic                          char_ready,
  output logic [rde_pkg::SYM_W-1:0]     character,
  output logic                          last
);
  import rde_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // register file never stalls a transfer
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: accept, alphabet check, divide loop, sign, digit readout
  rde_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // config registers, alphabet check, divider, digit store, output register
  rde_datapath #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .char_ready (char_ready),
    .char_valid (char_valid),
    .character  (character),
    .last       (last)
  );

endmodule

### rtl/rde_ram.sv
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rde_datapath.sv
module rde_datapath #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]      cfg_data,
  input  logic [VALUE_BITS-1:0]          value,
  input  rde_pkg::cmd_t                  cmd,
  output rde_pkg::status_t               status,
  input  logic                           char_ready,
  output logic                           char_valid,
  output logic [rde_pkg::SYM_W-1:0]      character,
  output logic                           last
);
  import rde_pkg::*;

  localparam int DIV_W   = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYC = DIV_W / DIV_STEPS;
  localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int AW      = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]             radix;
  logic [CFG_W-1:0]               symbols_low;
  logic [CFG_W-1:0]               symbols_high;
  logic [NUM_SYMBOLS*SYM_W-1:0]   symbols;
  logic [SYM_W-1:0]               sym [NUM_SYMBOLS];
  logic                           alphabet_bad;

  logic                           neg;
  logic [VALUE_BITS-1:0]          mag_in;
  logic [DIV_W-1:0]               mag;
  logic [DIV_W-1:0]               mag_next;
  logic [RADIX_W-1:0]             rem;
  logic [RADIX_W-1:0]             rem_next;
  logic [STEP_W-1:0]              step;
  logic [CNT_W-1:0]               count;
  logic [AW-1:0]                  ptr;
  logic [DIGIT_W-1:0]             rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIX:    radix        <= cfg_data[RADIX_W-1:0];
        REG_SYM_LOW:  symbols_low  <= cfg_data;
        REG_SYM_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign symbols = {symbols_high, symbols_low};

  always_comb begin
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      sym[i] = symbols[i*SYM_W +: SYM_W];
    end
  end

  // symbols past the radix are ignored
  always_comb begin
    alphabet_bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (RADIX_W'(i) < radix) begin
        if (sym_forbidden(sym[i])) begin
          alphabet_bad = 1'b1;
        end
        for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
          if ((RADIX_W'(j) < radix) && (sym[j] == sym[i])) begin
            alphabet_bad = 1'b1;
          end
        end
      end
    end
  end

  assign mag_in = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [RADIX_W-1:0] trial;
    rem_next = rem;
    mag_next = mag;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial    = {rem_next[RADIX_W-2:0], mag_next[DIV_W-1]};
      mag_next = {mag_next[DIV_W-2:0], 1'b0};
      if (trial >= radix) begin
        rem_next    = trial - radix;
        mag_next[0] = 1'b1;
      end else begin
        rem_next = trial;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_BITS-1];
      mag <= DIV_W'(mag_in);
    end else if (cmd.div_step) begin
      mag <= mag_next;
    end

    if (cmd.div_init) begin
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end

    if (cmd.load) begin
      count <= '0;
    end else if (cmd.digit_store) begin
      count <= count + CNT_W'(1);
    end

    if (cmd.digit_store) begin
      ptr <= count[AW-1:0];
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end
  end

  rde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (cmd.digit_store),
    .wr_addr (count[AW-1:0]),
    .wr_data (rem[DIGIT_W-1:0]),
    .rd_en   (cmd.rd_en),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= sym[rd_data];
      last      <= (ptr == '0);
    end
  end

  assign status.alphabet_ok = !alphabet_bad;
  assign status.neg         = neg;
  assign status.div_last    = (step == STEP_W'(DIV_CYC - 1));
  assign status.mag_zero    = (mag == '0);
  assign status.buf_full    = (count == CNT_W'(VALUE_BITS - 1));
  assign status.ptr_zero    = (ptr == '0);
  assign status.slot_free   = !char_valid || char_ready;

endmodule

### rtl/rde_ctrl.sv
module rde_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rde_pkg::status_t status,
  output rde_pkg::cmd_t    cmd
);
  import rde_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.alphabet_ok) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.digit_store = 1'b1;
        if (status.mag_zero || status.buf_full) begin
          state_next = S_SIGN;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_SIGN: begin
        if (!status.neg) begin
          state_next = S_FETCH;
        end else if (status.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (status.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
